@@ rtl/core/bqr_pkg.sv @@
// Shared types and constants for the bounded queue with remove at position.
// Depends on nothing; imported by the interfaces, controller, datapath and top.
package bqr_pkg;

  // Fixed widths of the channel fields
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned ITEM_W   = 16;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned CAP_W    = 5;

  // Capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ENTER  = 2'd0,
    ACT_LEAVE  = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_NOP    = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_DONE  = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2,
    STS_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_RESP = 2'd2
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // latch the request word
    logic execute;   // update the queue and load the response register
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic nop;       // latched action changes nothing
  } ctl_sts_t;

endpackage

@@ rtl/core/bqr_if.sv @@
// Valid/ready channel interfaces: request, response and capacity write.
// Depends on bqr_pkg for field widths.
interface bqr_req_if;
  import bqr_pkg::*;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [ITEM_W-1:0]   item_value;
  logic [POS_W-1:0]    position;
  modport source (output valid, action, item_value, position, input ready);
  modport sink   (input valid, action, item_value, position, output ready);
endinterface

interface bqr_rsp_if;
  import bqr_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ITEM_W-1:0]   removed_value;
  logic [COUNT_W-1:0]  entry_count;
  modport source (output valid, status, removed_value, entry_count, input ready);
  modport sink   (input valid, status, removed_value, entry_count, output ready);
endinterface

interface bqr_cfg_if;
  import bqr_pkg::*;
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ rtl/core/bqr_ctrl.sv @@
// Sequencer for the queue: take one request word, execute, hand out the response.
// Depends on bqr_pkg for the state, command and status types.
module bqr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  input  bqr_pkg::ctl_sts_t sts,
  output bqr_pkg::ctl_cmd_t cmd
);
  import bqr_pkg::*;

  state_t state, state_next;

  // Hold the current state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance on handshakes
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (rsp_ready) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Drive handshakes and datapath commands
  always_comb begin
    req_ready   = 1'b0;
    rsp_valid   = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
      end
      ST_EXEC: begin
        cmd.execute = !sts.nop;
      end
      ST_RESP: begin
        rsp_valid = 1'b1;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/core/bqr_dpath.sv @@
// Queue datapath: row of entry cells with gap-closing shift, count and capacity.
// Depends on bqr_pkg for widths, action and status codes, command and status types.
module bqr_dpath #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned VALUE_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  bqr_pkg::ctl_cmd_t               cmd,
  output bqr_pkg::ctl_sts_t               sts,
  input  logic [bqr_pkg::ACTION_W-1:0]    req_action,
  input  logic [bqr_pkg::ITEM_W-1:0]      req_item,
  input  logic [bqr_pkg::POS_W-1:0]       req_pos,
  input  logic                            cfg_we,
  input  logic [bqr_pkg::CAP_W-1:0]       cfg_data,
  output logic [bqr_pkg::STATUS_W-1:0]    rsp_status,
  output logic [bqr_pkg::ITEM_W-1:0]      rsp_removed,
  output logic [bqr_pkg::COUNT_W-1:0]     rsp_count
);
  import bqr_pkg::*;

  localparam int unsigned CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned IW   = $clog2(QUEUE_DEPTH);
  localparam int unsigned CMPW = (CW > POS_W) ? CW + 1 : POS_W + 1;
  localparam logic [CMPW-1:0] DEPTH_C = CMPW'(QUEUE_DEPTH);

  // Latched request word
  action_t           act;
  logic [ITEM_W-1:0] item;
  logic [POS_W-1:0]  pos;

  logic [CAP_W-1:0]      capacity;
  logic [CW-1:0]         cnt;
  logic [VALUE_BITS-1:0] slot [QUEUE_DEPTH];

  logic [STATUS_W-1:0] status_q;
  logic [ITEM_W-1:0]   removed_q;

  logic [CMPW-1:0]       cnt_w, cap_w, cap_lim, pos_w, idx_w;
  logic [IW-1:0]         idx;
  logic [VALUE_BITS-1:0] item_st, pick;
  logic [ITEM_W-1:0]     pick_out;
  logic                  do_enter, do_take;
  status_t               status_next;

  // Capture the request word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act  <= action_t'(req_action);
      item <= req_item;
      pos  <= req_pos;
    end
  end

  assign sts.nop = (act == ACT_NOP);

  // Hold the capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  // Fit the item to the stored width and the picked entry to the port width
  generate
    if (VALUE_BITS > ITEM_W) begin : g_wide
      assign item_st  = {{(VALUE_BITS-ITEM_W){1'b0}}, item};
      assign pick_out = pick[ITEM_W-1:0];
    end else if (VALUE_BITS == ITEM_W) begin : g_same
      assign item_st  = item;
      assign pick_out = pick;
    end else begin : g_narrow
      assign item_st  = item[VALUE_BITS-1:0];
      assign pick_out = {{(ITEM_W-VALUE_BITS){1'b0}}, pick};
    end
  endgenerate

  // Decide the action outcome
  always_comb begin
    cnt_w       = CMPW'(cnt);
    cap_w       = CMPW'(capacity);
    cap_lim     = (cap_w > DEPTH_C) ? DEPTH_C : cap_w;
    pos_w       = CMPW'(pos);
    idx_w       = '0;
    do_enter    = 1'b0;
    do_take     = 1'b0;
    status_next = STS_DONE;
    case (act)
      ACT_ENTER: begin
        if (cnt_w >= cap_lim) status_next = STS_FULL;
        else                  do_enter    = 1'b1;
      end
      ACT_LEAVE: begin
        if (cnt_w == '0) status_next = STS_EMPTY;
        else             do_take     = 1'b1;
      end
      ACT_REMOVE: begin
        if (pos_w > cnt_w)     status_next = STS_RANGE;
        else if (cnt_w == '0)  status_next = STS_EMPTY;
        else begin
          do_take = 1'b1;
          if (pos_w != '0) idx_w = pos_w - CMPW'(1);
        end
      end
      default: begin
        status_next = STS_DONE;
      end
    endcase
  end

  assign idx  = idx_w[IW-1:0];
  assign pick = slot[idx];

  // Update each cell: append at the rear, or close the gap behind the taken slot
  generate
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      if (i + 1 < QUEUE_DEPTH) begin : g_mid
        always_ff @(posedge clk) begin
          if (cmd.execute) begin
            if (do_enter && cnt == CW'(i)) begin
              slot[i] <= item_st;
            end else if (do_take && IW'(i) >= idx) begin
              slot[i] <= slot[i+1];
            end
          end
        end
      end else begin : g_last
        always_ff @(posedge clk) begin
          if (cmd.execute && do_enter && cnt == CW'(i)) begin
            slot[i] <= item_st;
          end
        end
      end
    end
  endgenerate

  // Advance the count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.execute) begin
      if (do_enter)     cnt <= cnt + CW'(1);
      else if (do_take) cnt <= cnt - CW'(1);
    end
  end

  // Load the response word; a no-op reports done with nothing removed
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      status_q  <= STS_DONE;
      removed_q <= '0;
    end else if (cmd.execute) begin
      status_q  <= status_next;
      removed_q <= do_take ? pick_out : '0;
    end
  end

  assign rsp_status  = status_q;
  assign rsp_removed = removed_q;
  generate
    if (CW >= COUNT_W) begin : g_cnt_cut
      assign rsp_count = cnt[COUNT_W-1:0];
    end else begin : g_cnt_ext
      assign rsp_count = {{(COUNT_W-CW){1'b0}}, cnt};
    end
  endgenerate

endmodule

@@ rtl/core/bounded_queue_remove_at_position.sv @@
// Top level of the bounded queue with remove at position.
// Depends on bqr_pkg, bqr_if, bqr_ctrl and bqr_dpath.
//
//  channel | dir | fields                                  | accepted when
//  --------+-----+-----------------------------------------+--------------------
//  req     | in  | action, item_value, position            | valid && ready
//  rsp     | out | status, removed_value, entry_count      | valid && ready
//
//  cfg     | in  | data (capacity)                         | valid && ready
//
// A request word is captured at its accepting edge and executed at the next edge.
// Its response word is valid from that edge on and holds until it is taken. The next
// request word is accepted only after the response is taken, so the block finishes
// one word before it takes another. A stalled response holds the request channel.
// The entry cells shift every entry behind the taken slot in the execute cycle.
// Synchronous reset empties the queue and sets capacity to 16; entry cells are not
// cleared. Capacity writes are always taken.
module bounded_queue_remove_at_position #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned VALUE_BITS  = 16
) (
  input logic   clk,
  input logic   rst,
  bqr_req_if.sink   req,
  bqr_rsp_if.source rsp,
  bqr_cfg_if.sink   cfg
);
  import bqr_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  assign cfg.ready = 1'b1;

  bqr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bqr_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .req_action  (req.action),
    .req_item    (req.item_value),
    .req_pos     (req.position),
    .cfg_we      (cfg.valid),
    .cfg_data    (cfg.data),
    .rsp_status  (rsp.status),
    .rsp_removed (rsp.removed_value),
    .rsp_count   (rsp.entry_count)
  );

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for bounded_queue_remove_at_position: directed table, then random
// phases under several capacities. Depends on bqr_pkg, the bqr_*_if interfaces and the RTL.
module tb;
  import bqr_pkg::*;

  localparam int unsigned DEPTH           = 16;
  localparam int unsigned PHASES          = 10;
  localparam int unsigned WORDS_PER_PHASE = 200;
  localparam int unsigned RANDOM_CAP_PHASE = 7;
  localparam int unsigned QUIET_LIMIT     = 1000;
  localparam int unsigned DRAIN_CYCLES    = 8;

  typedef struct packed {
    status_t            status;
    logic [ITEM_W-1:0]  removed;
    logic [COUNT_W-1:0] count;
  } outcome_t;

  typedef enum logic {ROW_WORD, ROW_CAP} row_kind_t;

  typedef enum logic [1:0] {SINK_STEADY, SINK_PATTERN, SINK_SPARSE} sink_mode_t;

  typedef struct packed {
    row_kind_t         kind;
    action_t           act;
    logic [ITEM_W-1:0] value;   // capacity in the low bits for a ROW_CAP row
    logic [POS_W-1:0]  pos;
    logic              has_want;
    outcome_t          want;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 25;

  // Empty-queue cases, extremes of the fields, then capacity edges
  localparam dir_row_t DIR_TABLE [0:DIR_ROWS-1] = '{
    '{ROW_WORD, ACT_LEAVE,  16'h0000, 8'd0,   1'b1, '{STS_EMPTY, 16'h0000, 5'd0}},
    '{ROW_WORD, ACT_REMOVE, 16'h0000, 8'd0,   1'b1, '{STS_EMPTY, 16'h0000, 5'd0}},
    '{ROW_WORD, ACT_REMOVE, 16'h0000, 8'd1,   1'b1, '{STS_RANGE, 16'h0000, 5'd0}},
    '{ROW_WORD, ACT_NOP,    16'hFFFF, 8'hFF,  1'b1, '{STS_DONE,  16'h0000, 5'd0}},
    '{ROW_WORD, ACT_ENTER,  16'hFFFF, 8'd0,   1'b1, '{STS_DONE,  16'h0000, 5'd1}},
    '{ROW_WORD, ACT_ENTER,  16'h0000, 8'hFF,  1'b1, '{STS_DONE,  16'h0000, 5'd2}},
    '{ROW_WORD, ACT_ENTER,  16'hA5A5, 8'd0,   1'b0, '{STS_DONE,  16'h0000, 5'd0}},
    '{ROW_WORD, ACT_REMOVE, 16'h0000, 8'hFF,  1'b1, '{STS_RANGE, 16'h0000, 5'd3}},
    '{ROW_WORD, ACT_REMOVE, 16'h0000, 8'd2,   1'b0, '{STS_DONE,  16'h0000, 5'd0}},
    '{ROW_WORD, ACT_REMOVE, 16'hFFFF, 8'd0,   1'b0, '{STS_DONE,  16'h0000, 5'd0}},
    '{ROW_WORD, ACT_LEAVE,  16'h0000, 8'd0,   1'b0, '{STS_DONE,  16'h0000, 5'd0}},
    '{ROW_CAP,  ACT_NOP,    16'd2,    8'd0,   1'b0, '{STS_DONE,  16'h0000, 5'd0}},
    '{ROW_WORD, ACT_ENTER,  16'h1234, 8'd0,   1'b0, '{STS_DONE,  16'h0000, 5'd0}},
    '{ROW_WORD, ACT_ENTER,  16'h5A5A, 8'd0,   1'b0, '{STS_DONE,  16'h0000, 5'd0}},
    '{ROW_WORD, ACT_ENTER,  16'h7777, 8'd0,   1'b1, '{STS_FULL,  16'h0000, 5'd2}},
    '{ROW_CAP,  ACT_NOP,    16'd1,    8'd0,   1'b0, '{STS_DONE,  16'h0000, 5'd0}},
    '{ROW_WORD, ACT_ENTER,  16'h0001, 8'd0,   1'b1, '{STS_FULL,  16'h0000, 5'd2}},
    '{ROW_WORD, ACT_REMOVE, 16'h0000, 8'd2,   1'b0, '{STS_DONE,  16'h0000, 5'd0}},
    '{ROW_CAP,  ACT_NOP,    16'd0,    8'd0,   1'b0, '{STS_DONE,  16'h0000, 5'd0}},
    '{ROW_WORD, ACT_ENTER,  16'h8000, 8'd0,   1'b1, '{STS_FULL,  16'h0000, 5'd1}},
    '{ROW_WORD, ACT_LEAVE,  16'h0000, 8'd0,   1'b0, '{STS_DONE,  16'h0000, 5'd0}},
    '{ROW_CAP,  ACT_NOP,    16'd31,   8'd0,   1'b0, '{STS_DONE,  16'h0000, 5'd0}},
    '{ROW_WORD, ACT_ENTER,  16'h00FF, 8'd0,   1'b0, '{STS_DONE,  16'h0000, 5'd0}},
    '{ROW_WORD, ACT_REMOVE, 16'h0000, 8'd1,   1'b0, '{STS_DONE,  16'h0000, 5'd0}},
    '{ROW_WORD, ACT_NOP,    16'h0000, 8'd0,   1'b1, '{STS_DONE,  16'h0000, 5'd0}}
  };

  localparam logic [CAP_W-1:0] PHASE_CAPS [0:PHASES-1] =
    '{5'd16, 5'd31, 5'd0, 5'd1, 5'd8, 5'd17, 5'd3, 5'd16, 5'd16, 5'd2};
  localparam int unsigned PHASE_ENTER [0:PHASES-1] =
    '{70, 75, 50, 60, 55, 80, 45, 50, 35, 65};

  logic clk;
  logic rst;

  bqr_req_if req_ch ();
  bqr_rsp_if rsp_ch ();
  bqr_cfg_if cfg_ch ();

  bounded_queue_remove_at_position #(
    .QUEUE_DEPTH(DEPTH),
    .VALUE_BITS (ITEM_W)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  // Shadow of the queue contents and capacity
  logic [ITEM_W-1:0] shadow_entries [$];
  logic [CAP_W-1:0]  shadow_cap;
  outcome_t          pending_outcomes [$];

  int         errors;
  int         burst_left;
  logic       gaps_on;
  sink_mode_t sink_mode;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Apply one word to the shadow queue and return the response it should produce
  function automatic outcome_t queue_step(action_t act, logic [ITEM_W-1:0] val,
                                          logic [POS_W-1:0] pos);
    outcome_t    res;
    int unsigned lim;
    int unsigned slot;
    res.status  = STS_DONE;
    res.removed = '0;
    lim = (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
    case (act)
      ACT_ENTER: begin
        if (shadow_entries.size() >= lim) res.status = STS_FULL;
        else shadow_entries.push_back(val);
      end
      ACT_LEAVE: begin
        if (shadow_entries.size() == 0) res.status = STS_EMPTY;
        else res.removed = shadow_entries.pop_front();
      end
      ACT_REMOVE: begin
        if (pos > shadow_entries.size()) begin
          res.status = STS_RANGE;
        end else if (shadow_entries.size() == 0) begin
          res.status = STS_EMPTY;
        end else begin
          slot = (pos == 0) ? 0 : pos - 1;
          res.removed = shadow_entries[slot];
          shadow_entries.delete(slot);
        end
      end
      default: ;
    endcase
    res.count = COUNT_W'(shadow_entries.size());
    return res;
  endfunction

  // Drive one request word in bursts with random gaps; predict on acceptance
  task automatic send_word(input action_t act, input logic [ITEM_W-1:0] val,
                           input logic [POS_W-1:0] pos, input logic has_want,
                           input outcome_t want);
    outcome_t    predicted;
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(1, 6) : 0;
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_ch.valid      <= 1'b1;
    req_ch.action     <= act;
    req_ch.item_value <= val;
    req_ch.position   <= pos;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = queue_step(act, val, pos);
    pending_outcomes.push_back(has_want ? want : predicted);
  endtask

  // Drain outstanding responses, then write the capacity register
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    req_ch.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= cap;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    shadow_cap = cap;
  endtask

  // Response sink: rotate a stall pattern, reload it at reset and each time pattern_age wraps
  logic [15:0] stall_pattern;
  int unsigned pattern_age;

  always @(posedge clk) begin
    if (rst || pattern_age == 47) begin
      pattern_age <= 0;
      case (sink_mode)
        SINK_STEADY:  stall_pattern <= 16'hFFFF;
        SINK_PATTERN: stall_pattern <= 16'($urandom) | 16'h0001;
        default:      stall_pattern <= (16'($urandom) & 16'($urandom)) | 16'h0001;
      endcase
    end else begin
      pattern_age   <= pattern_age + 1;
      stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
    end
    rsp_ch.ready <= rst ? 1'b0 : stall_pattern[0];
  end

  // Compare each response word with the oldest prediction
  outcome_t head_want;

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected response word: expected none, got status %0d value %h count %0d",
                 $time, rsp_ch.status, rsp_ch.removed_value, rsp_ch.entry_count);
        errors++;
      end else begin
        head_want = pending_outcomes.pop_front();
        if (rsp_ch.status !== head_want.status) begin
          $display("%0t: status mismatch: expected %0d, got %0d",
                   $time, head_want.status, rsp_ch.status);
          errors++;
        end
        if (rsp_ch.removed_value !== head_want.removed) begin
          $display("%0t: removed_value mismatch: expected %h, got %h",
                   $time, head_want.removed, rsp_ch.removed_value);
          errors++;
        end
        if (rsp_ch.entry_count !== head_want.count) begin
          $display("%0t: entry_count mismatch: expected %0d, got %0d",
                   $time, head_want.count, rsp_ch.entry_count);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run after too many cycles with no word moving
  int unsigned quiet_cycles;

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Main sequence: reset, directed table, random phases, drain
  initial begin : stimulus
    action_t           act;
    logic [POS_W-1:0]  pos;
    logic [CAP_W-1:0]  cap;
    int unsigned       pick;
    int unsigned       enter_pct;
    errors     = 0;
    burst_left = 0;
    gaps_on    = 1'b1;
    sink_mode  = SINK_PATTERN;
    shadow_cap = CAP_RESET;
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.action     <= ACT_NOP;
    req_ch.item_value <= '0;
    req_ch.position   <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.data       <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIR_TABLE[i].kind == ROW_CAP) begin
        write_capacity(DIR_TABLE[i].value[CAP_W-1:0]);
      end else begin
        send_word(DIR_TABLE[i].act, DIR_TABLE[i].value, DIR_TABLE[i].pos,
                  DIR_TABLE[i].has_want, DIR_TABLE[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      cap = (ph == RANDOM_CAP_PHASE) ? CAP_W'($urandom_range(31)) : PHASE_CAPS[ph];
      write_capacity(cap);
      enter_pct = PHASE_ENTER[ph];
      gaps_on   = (ph % 4 != 3);
      sink_mode = sink_mode_t'(ph % 3);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        // Pick the action; the remaining share splits between remove and leave, with picks of 97 and up as no-ops
        pick = $urandom_range(99);
        if (pick < enter_pct) act = ACT_ENTER;
        else if (pick < enter_pct + (100 - enter_pct) / 2) act = ACT_REMOVE;
        else if (pick < 97) act = ACT_LEAVE;
        else act = ACT_NOP;
        // Keep remove positions mostly in range, with some just past and some wild
        pick = $urandom_range(9);
        if (act != ACT_REMOVE || pick == 9) pos = POS_W'($urandom_range(255));
        else if (pick == 8) pos = POS_W'(shadow_entries.size() + 1);
        else pos = POS_W'($urandom_range(shadow_entries.size()));
        send_word(act, ITEM_W'($urandom), pos, 1'b0, '0);
      end
    end

    req_ch.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
